// ----- sv/rar_pkg.sv -----
// Shared types and constants for the rational adder with reduction.
package rar_pkg;

	localparam int OpW  = 16;
	localparam int NumW = 33;
	localparam int DenW = 31;
	localparam int MagW = 2 * OpW;
	localparam int CntW = $clog2(MagW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GCD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

// ----- sv/rar_datapath.sv -----
// Datapath: cross products, binary gcd and restoring division by the gcd.
module rar_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rar_pkg::cmd_t                 cmd,
	output rar_pkg::sts_t                 sts,
	input  logic [rar_pkg::OpW-1:0]       num_a,
	input  logic [rar_pkg::OpW-1:0]       den_a,
	input  logic [rar_pkg::OpW-1:0]       num_b,
	input  logic [rar_pkg::OpW-1:0]       den_b,
	output logic signed [rar_pkg::NumW-1:0] sum_num,
	output logic [rar_pkg::DenW-1:0]      sum_den,
	output logic                          status
);

	localparam int MW = rar_pkg::MagW;

	logic signed [rar_pkg::OpW-1:0] na_q, da_q, nb_q, db_q;
	logic signed [MW:0]             num_q;   // signed, one extra bit
	logic signed [MW:0]             den_q;
	logic [MW:0]                    ga_q, gb_q;
	logic [rar_pkg::CntW-1:0]       sh_q;
	logic [MW:0]                    g_q;
	logic [MW:0]                    qn_q, qd_q, rn_q, rd_q;
	logic [rar_pkg::CntW:0]         dc_q;
	logic                           sn_q, sd_q;
	logic                           ld_g_q;

	logic signed [MW-1:0] p_ad, p_bc, p_dd;
	logic [MW:0] mag_n, mag_d;
	logic [MW:0] ga_nx, gb_nx, dif;
	logic [MW+1:0] rn_sh, rd_sh;
	logic [MW:0] qn_f, qd_f;
	logic signed [MW+1:0] rnum;
	logic [MW:0] rden;

	assign sts.err      = (da_q == '0) || (db_q == '0);
	assign sts.gcd_done = (gb_q == '0);
	assign sts.div_done = (dc_q == '0);

	// operands widen to the product width before multiplying
	assign p_ad = na_q * db_q;
	assign p_bc = nb_q * da_q;
	assign p_dd = da_q * db_q;

	assign mag_n = num_q[MW] ? (MW+1)'(-num_q) : num_q;
	assign mag_d = den_q[MW] ? (MW+1)'(-den_q) : den_q;

	// binary gcd step on ga,gb (gcd(a,0)=a)
	always_comb begin
		ga_nx = ga_q;
		gb_nx = gb_q;
		dif   = '0;
		if (ga_q == '0) begin
			ga_nx = gb_q;
			gb_nx = '0;
		end else if (!ga_q[0] && !gb_q[0]) begin
			ga_nx = ga_q >> 1;
			gb_nx = gb_q >> 1;
		end else if (!ga_q[0]) begin
			ga_nx = ga_q >> 1;
		end else if (!gb_q[0]) begin
			gb_nx = gb_q >> 1;
		end else if (ga_q >= gb_q) begin
			dif   = ga_q - gb_q;
			ga_nx = gb_q;
			gb_nx = dif >> 1;
		end else begin
			dif   = gb_q - ga_q;
			gb_nx = dif >> 1;
		end
	end

	assign rn_sh = {rn_q, qn_q[MW]};
	assign rd_sh = {rd_q, qd_q[MW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
		end else if (cmd.div_start) begin
			dc_q <= (rar_pkg::CntW+1)'(MW + 1);
		end else if (cmd.div_step) begin
			dc_q <= dc_q - 1'b1;
		end
	end

	// gcd operands loaded the cycle after the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ld_g_q <= 1'b0;
		else         ld_g_q <= cmd.mul;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			na_q <= num_a;
			da_q <= den_a;
			nb_q <= num_b;
			db_q <= den_b;
		end
		if (cmd.mul) begin
			num_q <= {p_ad[MW-1], p_ad} + {p_bc[MW-1], p_bc};
			den_q <= {p_dd[MW-1], p_dd};
			sh_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (ga_q == '0) begin
				ga_q <= ga_nx;
				gb_q <= gb_nx;
			end else begin
				ga_q <= ga_nx;
				gb_q <= gb_nx;
				if (!ga_q[0] && !gb_q[0]) sh_q <= sh_q + 1'b1;
			end
		end else if (ld_g_q) begin
			ga_q <= mag_n;
			gb_q <= mag_d;
		end else if (cmd.mul) begin
			ga_q <= '0;
			gb_q <= '0;
		end
		if (cmd.div_start) begin
			g_q  <= ga_q << sh_q;
			qn_q <= mag_n;
			qd_q <= mag_d;
			sn_q <= num_q[MW];
			sd_q <= den_q[MW];
			rn_q <= '0;
			rd_q <= '0;
		end else if (cmd.div_step) begin
			if (rn_sh >= {1'b0, g_q}) begin
				rn_q <= (MW+1)'(rn_sh - {1'b0, g_q});
				qn_q <= {qn_q[MW-1:0], 1'b1};
			end else begin
				rn_q <= rn_sh[MW:0];
				qn_q <= {qn_q[MW-1:0], 1'b0};
			end
			if (rd_sh >= {1'b0, g_q}) begin
				rd_q <= (MW+1)'(rd_sh - {1'b0, g_q});
				qd_q <= {qd_q[MW-1:0], 1'b1};
			end else begin
				rd_q <= rd_sh[MW:0];
				qd_q <= {qd_q[MW-1:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (sts.err) begin
				sum_num <= '0;
				sum_den <= '0;
				status  <= 1'b1;
			end else if (qn_q == '0) begin
				sum_num <= '0;
				sum_den <= rar_pkg::DenW'(1);
				status  <= 1'b0;
			end else begin
				sum_num <= rar_pkg::NumW'(rnum);
				sum_den <= rar_pkg::DenW'(rden);
				status  <= 1'b0;
			end
		end
	end

	// sign of the quotient numerator: num sign xor den sign
	assign qn_f = qn_q;
	assign qd_f = qd_q;
	assign rnum = (sn_q ^ sd_q) ? -$signed({1'b0, qn_f}) : $signed({1'b0, qn_f});
	assign rden = qd_f;

endmodule

// ----- sv/rar_ctrl.sv -----
// Controller state machine sequencing the datapath.
module rar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  rar_pkg::sts_t sts,
	output rar_pkg::cmd_t cmd,
	output logic          gload
);

	rar_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rar_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rar_pkg::ST_IDLE: if (in_valid) state_nx = rar_pkg::ST_MUL;
			rar_pkg::ST_MUL:  state_nx = rar_pkg::ST_GCD;
			rar_pkg::ST_GCD: begin
				if (sts.err) state_nx = rar_pkg::ST_OUT;
				else if (sts.gcd_done && !gload) state_nx = rar_pkg::ST_DIV;
			end
			rar_pkg::ST_DIV: if (sts.div_done) state_nx = rar_pkg::ST_OUT;
			rar_pkg::ST_OUT: if (!out_stall) state_nx = rar_pkg::ST_IDLE;
			default: state_nx = rar_pkg::ST_IDLE;
		endcase
	end

	logic gl_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gl_q <= 1'b0;
		else         gl_q <= (state_q == rar_pkg::ST_MUL);
	end
	assign gload = gl_q;

	always_comb begin
		cmd = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			rar_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			rar_pkg::ST_MUL: cmd.mul = 1'b1;
			rar_pkg::ST_GCD: begin
				cmd.gcd_step = !gload && !sts.gcd_done;
				cmd.div_start = (sts.gcd_done && !gload) || sts.err;
				cmd.finish = sts.err;
			end
			rar_pkg::ST_DIV: begin
				cmd.div_step = !sts.div_done;
				cmd.finish   = sts.div_done;
			end
			rar_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.gcd_step, cmd.div_step}))
		else $error("conflicting commands");
`endif

endmodule

// ----- sv/rational_add_reduce.sv -----
// Top level of the rational adder with gcd reduction.
// Adds num_a/den_a and num_b/den_b, returns the sum in lowest terms.
// Input channel: in_valid/in_stall with num_a, den_a, num_b, den_b.
// Output channel: out_valid/out_stall with sum_num, sum_den, status.
// One transaction at a time: the accepting cycle loads the operands, the
// MUL state forms the cross products, the first GCD cycle loads the gcd
// operands, then the binary gcd runs at one shift or subtract a cycle on
// 33-bit magnitudes, div_start begins the division, and bit-serial
// division of numerator and denominator by the gcd and the write of the
// result follow.
// out_valid rises once the gcd loop and the serial divider are done.
// The next input is taken the cycle after the result is taken.
// A zero denominator skips the gcd and returns 0/0 with status 1.
// A zero sum returns 0/1. The denominator is positive but for 0/0 errors.
// Reset clears the controller; no transaction is then pending.
// While the receiver stalls the result holds and no input is taken.
module rational_add_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rar_pkg::OpW-1:0]       num_a,
	input  logic [rar_pkg::OpW-1:0]       den_a,
	input  logic [rar_pkg::OpW-1:0]       num_b,
	input  logic [rar_pkg::OpW-1:0]       den_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [rar_pkg::NumW-1:0] sum_num,
	output logic [rar_pkg::DenW-1:0]      sum_den,
	output logic                          status
);

	rar_pkg::cmd_t cmd;
	rar_pkg::sts_t sts;
	logic gload;
	rar_pkg::cmd_t dcmd;

	rar_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
		.gload(gload)
	);

	// the gcd registers take the magnitudes in the cycle after the products
	always_comb begin
		dcmd = cmd;
	end

	rar_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd), .sts(sts),
		.num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.sum_num(sum_num), .sum_den(sum_den), .status(status)
	);

endmodule

// ----- dv/tb.sv -----
// Testbench for rational_add_reduce: directed table, then randomised fractions under idling and receiver stalls.
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic signed [32:0] num;
		logic [30:0]        den;
		logic               err;
	} frac_sum_t;

	typedef struct packed {
		logic [15:0] na;
		logic [15:0] da;
		logic [15:0] nb;
		logic [15:0] db;
		bit          typed;
		frac_sum_t   want;
	} stim_row_t;

	localparam int NROWS = 18;
	localparam stim_row_t STIM_TABLE [NROWS] = '{
		'{16'd1,      16'd2,      16'd1,      16'd3,      1'b0, '{0, 0, 0}},
		'{16'd3,      16'd0,      16'd1,      16'd1,      1'b1, '{0, 0, 1}},
		'{16'd1,      16'd1,      16'd5,      16'd0,      1'b1, '{0, 0, 1}},
		'{16'd0,      16'd0,      16'd0,      16'd0,      1'b1, '{0, 0, 1}},
		'{16'd0,      16'd5,      16'd0,      16'hfffd,   1'b1, '{0, 1, 0}},
		'{16'd7,      16'd3,      16'hfff9,   16'd3,      1'b1, '{0, 1, 0}},
		'{16'h8000,   16'h8000,   16'h8000,   16'h8000,   1'b1, '{2, 1, 0}},
		'{16'h7fff,   16'd1,      16'h7fff,   16'd1,      1'b1, '{65534, 1, 0}},
		'{16'h8000,   16'd1,      16'h8000,   16'd1,      1'b1, '{-65536, 1, 0}},
		'{16'd1,      16'hffff,   16'd0,      16'd1,      1'b1, '{-1, 1, 0}},
		'{16'd1,      16'h7fff,   16'd1,      16'h8000,   1'b0, '{0, 0, 0}},
		'{16'h7fff,   16'h8000,   16'h7fff,   16'h8000,   1'b0, '{0, 0, 0}},
		'{16'h8000,   16'h7fff,   16'h8000,   16'h7fff,   1'b0, '{0, 0, 0}},
		'{16'd1,      16'h8000,   16'd1,      16'h8000,   1'b1, '{-1, 16384, 0}},
		'{16'hffff,   16'hffff,   16'd1,      16'd1,      1'b1, '{2, 1, 0}},
		'{16'd6,      16'd4,      16'd2,      16'hfffc,   1'b1, '{1, 1, 0}},
		'{16'h7fff,   16'd1,      16'h8000,   16'd1,      1'b1, '{-1, 1, 0}},
		'{16'h5555,   16'haaaa,   16'haaaa,   16'h5555,   1'b0, '{0, 0, 0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [rar_pkg::NumW-1:0] sum_num;
	logic [rar_pkg::DenW-1:0]        sum_den;
	logic        status;

	// side-band carried with the payload so the monitor knows a typed answer
	logic        row_typed = 1'b0;
	frac_sum_t   row_want = '0;

	frac_sum_t   pending_sums [$];
	int          fail_cnt = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;

	rational_add_reduce dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic frac_sum_t reduce_sum(logic [15:0] na_r, logic [15:0] da_r,
			logic [15:0] nb_r, logic [15:0] db_r);
		frac_sum_t res;
		longint na, da, nb, db, n, d;
		longint unsigned x, y, t;
		na = longint'($signed(na_r));
		da = longint'($signed(da_r));
		nb = longint'($signed(nb_r));
		db = longint'($signed(db_r));
		res = '0;
		if (da == 0 || db == 0) begin
			res.err = 1'b1;
			return res;
		end
		n = na * db + nb * da;
		d = da * db;
		x = (n < 0) ? -n : n;
		y = (d < 0) ? -d : d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		n = n / longint'(x);
		d = d / longint'(x);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (n == 0)
			d = 1;
		res.num = n[32:0];
		res.den = d[30:0];
		return res;
	endfunction

	task automatic offer(stim_row_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		num_a     <= r.na;
		den_a     <= r.da;
		num_b     <= r.nb;
		den_b     <= r.db;
		row_typed <= r.typed;
		row_want  <= r.want;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic logic [15:0] rand_field(bit is_den);
		int sel;
		sel = $urandom_range(0, 99);
		if (is_den && sel < 4)
			return 16'd0;
		if (sel < 45)
			return 16'($urandom_range(0, 40) - 20);
		if (sel < 52)
			return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
		return 16'($urandom());
	endfunction

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_req && !hold_done && hold_left == 0) begin
			hold_left <= 700;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1) ? 1'b1 : 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		frac_sum_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_sums.push_back(row_typed ? row_want :
					reduce_sum(num_a, den_a, num_b, den_b));
			if (out_valid && !out_stall) begin
				if (pending_sums.size() == 0) begin
					$display("%0t: unexpected result %0d/%0d status %0d", $time,
						sum_num, sum_den, status);
					fail_cnt++;
				end else begin
					want = pending_sums.pop_front();
					if (sum_num !== want.num) begin
						$display("%0t: sum_num expected %0d actual %0d", $time,
							want.num, sum_num);
						fail_cnt++;
					end
					if (sum_den !== want.den) begin
						$display("%0t: sum_den expected %0d actual %0d", $time,
							want.den, sum_den);
						fail_cnt++;
					end
					if (status !== want.err) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.err, status);
						fail_cnt++;
					end
				end
			end
		end
	end

	initial begin
		stim_row_t r;
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (STIM_TABLE[i])
			offer(STIM_TABLE[i]);
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 69 : 25) : 0;
			stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 69 : 25) : 0;
			if (phase == 1)
				hold_req <= 1'b1;
			for (int k = 0; k < 358; k++) begin
				r.na    = rand_field(1'b0);
				r.da    = rand_field(1'b1);
				r.nb    = rand_field(1'b0);
				r.db    = rand_field(1'b1);
				r.typed = 1'b0;
				r.want  = '0;
				offer(r);
			end
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending_sums.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (fail_cnt == 0 && pending_sums.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
